/* rtl/core/hsv2rgb_pkg.sv */
// Shared types and constants for the HSV to RGB converter.
// No dependencies; imported by every module of the converter.
package hsv2rgb_pkg;

   localparam int HUE_FRAC_BITS_DEF     = 6;
   localparam int PERCENT_FRAC_BITS_DEF = 8;

   localparam int IN_W = 16;
   localparam int CH_W = 8;
   localparam int NUM_CH = 3;

   // channel lanes
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;

   // Full-scale denominator is DIV_D << (2*PERCENT_FRAC_BITS + HUE_FRAC_BITS)
   localparam int N_W       = 28;
   localparam int DIV_W     = 20;
   localparam logic [DIV_W-1:0] DIV_D = DIV_W'(600000);
   localparam int RECIP_SH  = 48;
   localparam int RECIP_W   = 29;
   localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'((64'd1 << RECIP_SH) / 64'd600000);

   typedef enum logic [2:0] {
      SEC_RED_YEL,
      SEC_YEL_GRN,
      SEC_GRN_CYA,
      SEC_CYA_BLU,
      SEC_BLU_MAG,
      SEC_MAG_RED
   } sector_type;

   typedef struct packed {
      logic valid;
      logic reject;
   } ctl_type;

endpackage

/* rtl/core/hsv2rgb_front.sv */
// Input stage: range check, hue sector and per-channel weight selection.
// Depends on hsv2rgb_pkg.
module hsv2rgb_front
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS     = HUE_FRAC_BITS_DEF,
   parameter int PERCENT_FRAC_BITS = PERCENT_FRAC_BITS_DEF,
   localparam int D_VAL  = 60 << HUE_FRAC_BITS,
   localparam int P_VAL  = 100 << PERCENT_FRAC_BITS,
   localparam int S_W    = $clog2(P_VAL + 1),
   localparam int DIST_W = $clog2(D_VAL + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic signed [IN_W-1:0]          hue,
   input  logic signed [IN_W-1:0]          saturation,
   input  logic signed [IN_W-1:0]          brightness,
   output ctl_type                         ctl_ff,
   output logic [S_W-1:0]                  sat_ff,
   output logic [S_W-1:0]                  bri_ff,
   output logic [NUM_CH-1:0][DIST_W-1:0]   t_ff
);

   localparam int H_W = $clog2((360 << HUE_FRAC_BITS) + 1);
   localparam logic signed [IN_W-1:0] HUE_MAX_S = IN_W'(360 << HUE_FRAC_BITS);
   localparam logic signed [IN_W-1:0] PCT_MAX_S = IN_W'(100 << PERCENT_FRAC_BITS);
   localparam logic [DIST_W-1:0] D_T = DIST_W'(D_VAL);

   ctl_type                         ctl_in;
   logic [S_W-1:0]                  sat_in;
   logic [S_W-1:0]                  bri_in;
   logic [NUM_CH-1:0][DIST_W-1:0]   t_in;
   logic                            reject;
   logic [H_W-1:0]                  hu;
   logic [H_W-1:0]                  base;
   logic [DIST_W-1:0]               off;
   logic [DIST_W-1:0]               hue_dist;
   sector_type                      sector;

   always_comb begin
      reject = hue[IN_W-1] || (hue > HUE_MAX_S) ||
               saturation[IN_W-1] || (saturation > PCT_MAX_S) ||
               brightness[IN_W-1] || (brightness > PCT_MAX_S);
      hu = hue[H_W-1:0];

      // hue 360 stays in the last sector
      if (hu >= H_W'(5 * D_VAL))      sector = SEC_MAG_RED;
      else if (hu >= H_W'(4 * D_VAL)) sector = SEC_BLU_MAG;
      else if (hu >= H_W'(3 * D_VAL)) sector = SEC_CYA_BLU;
      else if (hu >= H_W'(2 * D_VAL)) sector = SEC_GRN_CYA;
      else if (hu >= H_W'(D_VAL))     sector = SEC_YEL_GRN;
      else                            sector = SEC_RED_YEL;

      case (sector)
         SEC_RED_YEL: base = '0;
         SEC_YEL_GRN: base = H_W'(D_VAL);
         SEC_GRN_CYA: base = H_W'(2 * D_VAL);
         SEC_CYA_BLU: base = H_W'(3 * D_VAL);
         SEC_BLU_MAG: base = H_W'(4 * D_VAL);
         default:     base = H_W'(5 * D_VAL);
      endcase
      off = DIST_W'(hu - base);

      // weight t: chroma -> 0, second component -> hue_dist, zero -> full span
      t_in = '0;
      hue_dist = D_T - off;
      case (sector)
         SEC_RED_YEL: begin
            t_in[CH_RED] = '0;       t_in[CH_GREEN] = hue_dist; t_in[CH_BLUE] = D_T;
         end
         SEC_YEL_GRN: begin
            hue_dist = off;
            t_in[CH_RED] = hue_dist; t_in[CH_GREEN] = '0;       t_in[CH_BLUE] = D_T;
         end
         SEC_GRN_CYA: begin
            t_in[CH_RED] = D_T;      t_in[CH_GREEN] = '0;       t_in[CH_BLUE] = hue_dist;
         end
         SEC_CYA_BLU: begin
            hue_dist = off;
            t_in[CH_RED] = D_T;      t_in[CH_GREEN] = hue_dist; t_in[CH_BLUE] = '0;
         end
         SEC_BLU_MAG: begin
            t_in[CH_RED] = hue_dist; t_in[CH_GREEN] = D_T;      t_in[CH_BLUE] = '0;
         end
         default: begin
            hue_dist = off;
            t_in[CH_RED] = '0;       t_in[CH_GREEN] = D_T;      t_in[CH_BLUE] = hue_dist;
         end
      endcase

      // zero the operands of a rejected item so the datapath stays bounded
      sat_in = reject ? '0 : saturation[S_W-1:0];
      bri_in = reject ? '0 : brightness[S_W-1:0];
      ctl_in.valid  = accept;
      ctl_in.reject = reject;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      sat_ff <= sat_in;
      bri_ff <= bri_in;
      t_ff   <= t_in;
   end

endmodule

/* rtl/core/hsv2rgb_chan.sv */
// One colour lane: weight product, value product and 255 scaling.
// Depends on hsv2rgb_pkg.
module hsv2rgb_chan
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS     = HUE_FRAC_BITS_DEF,
   parameter int PERCENT_FRAC_BITS = PERCENT_FRAC_BITS_DEF,
   localparam int D_VAL  = 60 << HUE_FRAC_BITS,
   localparam int P_VAL  = 100 << PERCENT_FRAC_BITS,
   localparam int S_W    = $clog2(P_VAL + 1),
   localparam int DIST_W = $clog2(D_VAL + 1)
) (
   input  logic              clock,
   input  logic [S_W-1:0]    sat,
   input  logic [S_W-1:0]    bri,
   input  logic [DIST_W-1:0] t,
   output logic [N_W-1:0]    n_ff
);

   localparam int PD_VAL = P_VAL * D_VAL;
   localparam int PD_W   = $clog2(PD_VAL + 1);
   localparam int M_W    = S_W + PD_W;
   localparam int SC_W   = M_W + CH_W;
   localparam int SH     = 2 * PERCENT_FRAC_BITS + HUE_FRAC_BITS;

   logic [PD_W-1:0] p_in, p_ff;
   logic [S_W-1:0]  v1_ff;
   logic [PD_W-1:0] w;
   logic [M_W-1:0]  m_in, m_ff;
   logic [SC_W-1:0] sc;
   logic [N_W-1:0]  n_in;

   always_comb begin
      p_in = PD_W'(sat) * PD_W'(t);
      w    = PD_W'(PD_VAL) - p_ff;
      m_in = M_W'(v1_ff) * M_W'(w);
      // times 255, then drop the power-of-two part of the denominator
      sc   = {m_ff, {CH_W{1'b0}}} - SC_W'(m_ff);
      n_in = N_W'(sc >> SH);
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      v1_ff <= bri;
      m_ff  <= m_in;
      n_ff  <= n_in;
   end

endmodule

/* rtl/core/hsv2rgb_cdiv.sv */
// Division by the constant 600000: reciprocal multiply, then one correction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_cdiv
   import hsv2rgb_pkg::*;
(
   input  logic            clock,
   input  logic [N_W-1:0]  n,
   output logic [CH_W-1:0] q_ff
);

   localparam int PROD_W = N_W + RECIP_W;

   logic [PROD_W-1:0] prod;
   logic [CH_W-1:0]   qe_in, qe_ff;
   logic [N_W-1:0]    n2_ff;
   logic [N_W-1:0]    qd;
   logic [N_W-1:0]    rem;
   logic [CH_W-1:0]   q_in;

   always_comb begin
      prod  = PROD_W'(n) * PROD_W'(RECIP_M);
      // estimate is low by at most one
      qe_in = prod[RECIP_SH +: CH_W];
      qd    = N_W'(qe_ff) * N_W'(DIV_D);
      rem   = n2_ff - qd;
      q_in  = qe_ff + CH_W'(rem >= N_W'(DIV_D));
   end

   always_ff @(posedge clock) begin
      qe_ff <= qe_in;
      n2_ff <= n;
      q_ff  <= q_in;
   end

endmodule

/* rtl/core/hsv_to_rgb_converter.sv */
// Top level of the HSV to RGB converter.
// Depends on hsv2rgb_pkg, hsv2rgb_front, hsv2rgb_chan and hsv2rgb_cdiv.
//
// Usage:
//   Input channel: drive req_hue, req_saturation and req_brightness and raise
//   start; a transfer takes place at every rising edge with start high and
//   busy low. busy is high only while reset is asserted, so one colour may
//   be transferred in every cycle.
//   Result channel: rsp_valid is high for exactly one cycle per colour, with
//   rsp_red, rsp_green, rsp_blue and rsp_input_rejected alongside. Results
//   leave in transfer order.
//   Each colour passes through the six-stage pipeline (front, weight product,
//   value product, scaling, reciprocal multiply, correction), with all three
//   lanes in parallel. Throughput: one colour per cycle.
//   Out-of-range inputs give black with rsp_input_rejected set.
//   Reset: synchronous; clears every valid bit so no result emerges from
//   colours in flight. The datapath registers are not reset.
//   The receiver cannot stall: results must be taken when strobed.
module hsv_to_rgb_converter
   import hsv2rgb_pkg::*;
#(
   parameter int HUE_FRAC_BITS     = HUE_FRAC_BITS_DEF,
   parameter int PERCENT_FRAC_BITS = PERCENT_FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic signed [IN_W-1:0] req_hue,
   input  logic signed [IN_W-1:0] req_saturation,
   input  logic signed [IN_W-1:0] req_brightness,
   output logic                   rsp_valid,
   output logic [CH_W-1:0]        rsp_red,
   output logic [CH_W-1:0]        rsp_green,
   output logic [CH_W-1:0]        rsp_blue,
   output logic                   rsp_input_rejected
);

   localparam int D_VAL   = 60 << HUE_FRAC_BITS;
   localparam int P_VAL   = 100 << PERCENT_FRAC_BITS;
   localparam int S_W     = $clog2(P_VAL + 1);
   localparam int DIST_W  = $clog2(D_VAL + 1);
   localparam int CTL_DEP = 5;   // stages behind the front register

   ctl_type                         front_ctl;
   logic [S_W-1:0]                  sat;
   logic [S_W-1:0]                  bri;
   logic [NUM_CH-1:0][DIST_W-1:0]   t;
   logic [NUM_CH-1:0][N_W-1:0]      n;
   logic [NUM_CH-1:0][CH_W-1:0]     q;
   ctl_type                         ctl_ff [CTL_DEP];
   logic                            accept;

   // hold off transfers only while in reset
   assign busy   = reset;
   assign accept = start && !busy;

   hsv2rgb_front #(
      .HUE_FRAC_BITS     (HUE_FRAC_BITS),
      .PERCENT_FRAC_BITS (PERCENT_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .hue        (req_hue),
      .saturation (req_saturation),
      .brightness (req_brightness),
      .ctl_ff     (front_ctl),
      .sat_ff     (sat),
      .bri_ff     (bri),
      .t_ff       (t)
   );

   // one lane per colour channel, all in lock step
   for (genvar i = 0; i < NUM_CH; i++) begin : g_lane
      hsv2rgb_chan #(
         .HUE_FRAC_BITS     (HUE_FRAC_BITS),
         .PERCENT_FRAC_BITS (PERCENT_FRAC_BITS)
      ) u_chan (
         .clock (clock),
         .sat   (sat),
         .bri   (bri),
         .t     (t[i]),
         .n_ff  (n[i])
      );

      hsv2rgb_cdiv u_cdiv (
         .clock (clock),
         .n     (n[i]),
         .q_ff  (q[i])
      );
   end

   // advance the valid and reject bits alongside the lanes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CTL_DEP; k++) begin
            ctl_ff[k] <= '0;
         end
      end else begin
         ctl_ff[0] <= front_ctl;
         for (int k = 1; k < CTL_DEP; k++) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
   end

   // drop the lane results of a rejected colour: black
   assign rsp_valid          = ctl_ff[CTL_DEP-1].valid;
   assign rsp_input_rejected = ctl_ff[CTL_DEP-1].reject;
   assign rsp_red   = ctl_ff[CTL_DEP-1].reject ? '0 : q[CH_RED];
   assign rsp_green = ctl_ff[CTL_DEP-1].reject ? '0 : q[CH_GREEN];
   assign rsp_blue  = ctl_ff[CTL_DEP-1].reject ? '0 : q[CH_BLUE];

`ifndef SYNTHESIS
   localparam logic signed [IN_W-1:0] A_HUE_MAX = IN_W'(360 << HUE_FRAC_BITS);
   localparam logic signed [IN_W-1:0] A_PCT_MAX = IN_W'(100 << PERCENT_FRAC_BITS);

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("accepted colour did not produce a result six cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("result strobe without a matching transfer");

   a_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_brightness == '0, 6) |->
         rsp_red == '0 && rsp_green == '0 && rsp_blue == '0)
      else $error("zero brightness did not give black");

   a_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(req_saturation == '0 && req_brightness == A_PCT_MAX &&
                         !req_hue[IN_W-1] && req_hue <= A_HUE_MAX, 6) |->
         rsp_red == '1 && rsp_green == '1 && rsp_blue == '1 && !rsp_input_rejected)
      else $error("full brightness with no saturation did not give white");
`endif

endmodule

/* bench/tb_hsv_to_rgb_converter.sv */
// Self-checking bench for hsv_to_rgb_converter: directed table, then random colours.
// Depends on hsv2rgb_pkg and the hsv_to_rgb_converter RTL; reads no files.
`timescale 1ns / 1ps

module tb_hsv_to_rgb_converter;
   import hsv2rgb_pkg::*;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 1050;
   localparam int BURST_LEN    = 40;
   localparam int MAX_GAP      = 10;
   // pipeline is six deep; wait this long after the last expected colour for stray strobes
   localparam int DRAIN_CYCLES = 12;
   // slowest run: ~1075 transfers with idle gaps, plus the midway and final drains
   localparam int CYCLE_LIMIT  = 200000;

   // fixed-point scales of the inputs
   localparam int HUE_SPAN = 60 << HUE_FRAC_BITS_DEF;
   localparam int HUE_TOP  = 360 << HUE_FRAC_BITS_DEF;
   localparam int PCT_TOP  = 100 << PERCENT_FRAC_BITS_DEF;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            rejected;
   } colour_type;

   // one row of the directed table; want is used only where known is set
   typedef struct packed {
      logic signed [IN_W-1:0] hue;
      logic signed [IN_W-1:0] sat;
      logic signed [IN_W-1:0] bri;
      logic                   known;
      colour_type             want;
   } probe_type;

   localparam int NUM_PROBES = 25;
   localparam probe_type PROBES [0:NUM_PROBES-1] = '{
      // zero everything: black, accepted
      '{16'sd0,      16'sd0,      16'sd0,      1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}},
      // full saturation and value at each sector boundary
      '{16'sd0,      16'sd25600,  16'sd25600,  1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
      '{16'sd3840,   16'sd25600,  16'sd25600,  1'b1, '{8'd255, 8'd255, 8'd0,   1'b0}},
      '{16'sd7680,   16'sd25600,  16'sd25600,  1'b1, '{8'd0,   8'd255, 8'd0,   1'b0}},
      '{16'sd11520,  16'sd25600,  16'sd25600,  1'b1, '{8'd0,   8'd255, 8'd255, 1'b0}},
      '{16'sd15360,  16'sd25600,  16'sd25600,  1'b1, '{8'd0,   8'd0,   8'd255, 1'b0}},
      '{16'sd19200,  16'sd25600,  16'sd25600,  1'b1, '{8'd255, 8'd0,   8'd255, 1'b0}},
      // hue of exactly 360 degrees lands in the last sector: pure red
      '{16'sd23040,  16'sd25600,  16'sd25600,  1'b1, '{8'd255, 8'd0,   8'd0,   1'b0}},
      // no saturation at full value: white whatever the hue
      '{16'sd12345,  16'sd0,      16'sd25600,  1'b1, '{8'd255, 8'd255, 8'd255, 1'b0}},
      // out of range on each field, both sides: black and rejected
      '{16'sd23041,  16'sd25600,  16'sd25600,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{-16'sd1,     16'sd25600,  16'sd25600,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{16'sd0,      -16'sd1,     16'sd12800,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{16'sd0,      16'sd25601,  16'sd25600,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{16'sd0,      16'sd25600,  16'sd25601,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{16'sd0,      16'sd0,      -16'sd32768, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{16'sd32767,  16'sd32767,  16'sd32767,  1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b1, '{8'd0,   8'd0,   8'd0,   1'b1}},
      // mid-sector and near-boundary hues, small and odd magnitudes
      '{16'sd1920,   16'sd25600,  16'sd25600,  1'b0, '0},
      '{16'sd23039,  16'sd25600,  16'sd25600,  1'b0, '0},
      '{16'sd7679,   16'sd12800,  16'sd25600,  1'b0, '0},
      '{16'sd1,      16'sd1,      16'sd1,      1'b0, '0},
      '{16'sd19201,  16'sd25599,  16'sd12800,  1'b0, '0},
      '{16'sd3839,   16'sd25600,  16'sd1,      1'b0, '0},
      '{16'sd17000,  16'sd20000,  16'sd25600,  1'b0, '0},
      // full saturation, zero value: black, accepted
      '{16'sd0,      16'sd25600,  16'sd0,      1'b1, '{8'd0,   8'd0,   8'd0,   1'b0}}
   };

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic signed [IN_W-1:0] req_hue;
   logic signed [IN_W-1:0] req_saturation;
   logic signed [IN_W-1:0] req_brightness;
   logic                   rsp_valid;
   logic [CH_W-1:0]        rsp_red;
   logic [CH_W-1:0]        rsp_green;
   logic [CH_W-1:0]        rsp_blue;
   logic                   rsp_input_rejected;

   // colours still owed by the converter, oldest first
   colour_type pending_colours [$];
   int         mismatch_count = 0;
   int         cycle_count    = 0;

   hsv_to_rgb_converter dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_hue            (req_hue),
      .req_saturation     (req_saturation),
      .req_brightness     (req_brightness),
      .rsp_valid          (rsp_valid),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .rsp_input_rejected (rsp_input_rejected)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Scale one channel plus the value offset to 0..255, truncating once at the end.
   function automatic logic [CH_W-1:0] scale_channel(longint unsigned part,
                                                     longint unsigned offset,
                                                     longint unsigned denom);
      longint unsigned level;
      level = ((part + offset) * 64'd255) / denom;
      if (level > 64'd255)
         level = 64'd255;
      return CH_W'(level);
   endfunction

   // Work out the colour expected for one HSV transfer. All terms share one
   // denominator (percent scale squared times sector span), so nothing is
   // rounded before the final truncation.
   function automatic colour_type predict_colour(logic signed [IN_W-1:0] hue,
                                                 logic signed [IN_W-1:0] sat,
                                                 logic signed [IN_W-1:0] bri);
      colour_type      colour;
      longint unsigned h, s, v, span, pct, denom;
      longint unsigned chroma, xpart, offset, hm, hue_dist, sec;
      longint unsigned rp, gp, bp;
      sector_type      sect;
      colour = '0;
      if (hue < 0 || hue > HUE_TOP || sat < 0 || sat > PCT_TOP ||
          bri < 0 || bri > PCT_TOP) begin
         colour.rejected = 1'b1;
         return colour;
      end
      h      = hue;
      s      = sat;
      v      = bri;
      span   = HUE_SPAN;
      pct    = PCT_TOP;
      denom  = pct * pct * span;
      chroma = s * v * span;
      offset = v * pct * span - chroma;
      // distance of the hue from the middle of its double sector
      hm       = h % (2 * span);
      hue_dist = (hm >= span) ? hm - span : span - hm;
      xpart    = s * v * (span - hue_dist);
      // 360 degrees would be sector six: fold it into the last one
      sec    = h / span;
      if (sec > 5)
         sec = 5;
      sect = sector_type'(sec[2:0]);
      case (sect)
         SEC_RED_YEL: begin
            rp = chroma; gp = xpart;  bp = 0;
         end
         SEC_YEL_GRN: begin
            rp = xpart;  gp = chroma; bp = 0;
         end
         SEC_GRN_CYA: begin
            rp = 0;      gp = chroma; bp = xpart;
         end
         SEC_CYA_BLU: begin
            rp = 0;      gp = xpart;  bp = chroma;
         end
         SEC_BLU_MAG: begin
            rp = xpart;  gp = 0;      bp = chroma;
         end
         default: begin
            rp = chroma; gp = 0;      bp = xpart;
         end
      endcase
      colour.red   = scale_channel(rp, offset, denom);
      colour.green = scale_channel(gp, offset, denom);
      colour.blue  = scale_channel(bp, offset, denom);
      return colour;
   endfunction

   // Draw one field: mostly in range, some boundary values, some raw 16-bit noise
   // so that every bit, the sign bit included, takes both values.
   function automatic logic signed [IN_W-1:0] draw_field(int top);
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 80)
         return IN_W'($urandom_range(0, top));
      if (kind < 90) begin
         case ($urandom_range(0, 4))
            0:       return '0;
            1:       return IN_W'(top);
            2:       return IN_W'(top + 1);
            3:       return IN_W'(top - 1);
            default: return '1;
         endcase
      end
      return IN_W'($urandom);
   endfunction

   // Present one colour after an idle gap and hold it until the transfer.
   // busy is sampled at the falling edge, where it is settled for the next rising
   // edge; the expectation is queued there, well before its result can appear.
   task automatic send_colour(input logic signed [IN_W-1:0] hue,
                              input logic signed [IN_W-1:0] sat,
                              input logic signed [IN_W-1:0] bri,
                              input colour_type want,
                              input int gap);
      bit took;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_hue        <= hue;
      req_saturation <= sat;
      req_brightness <= bri;
      start          <= 1'b1;
      do begin
         @(negedge clock);
         took = !busy;
         if (took)
            pending_colours.push_back(want);
         @(posedge clock);
      end while (!took);
   endtask

   // Stimulus: hold reset, walk the directed table, then random colours in bursts.
   initial begin
      bit                     quiet;
      logic signed [IN_W-1:0] hue, sat, bri;
      colour_type             want;
      reset          = 1'b1;
      start          = 1'b0;
      req_hue        = '0;
      req_saturation = '0;
      req_brightness = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: typed-in colour where it is obvious, predicted otherwise
      for (int i = 0; i < NUM_PROBES; i++) begin
         want = PROBES[i].known ? PROBES[i].want
                                : predict_colour(PROBES[i].hue, PROBES[i].sat, PROBES[i].bri);
         send_colour(PROBES[i].hue, PROBES[i].sat, PROBES[i].bri, want,
                     $urandom_range(0, MAX_GAP));
      end

      // random: every burst is either back-to-back or with drawn gaps
      quiet = 1'b0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % BURST_LEN == 0)
            quiet = ($urandom_range(0, 3) == 0);
         // halfway through, drop start and let the pipeline empty completely
         if (i == RANDOM_ITEMS / 2) begin
            start <= 1'b0;
            do @(posedge clock); while (pending_colours.size() != 0);
         end
         hue = draw_field(HUE_TOP);
         sat = draw_field(PCT_TOP);
         bri = draw_field(PCT_TOP);
         send_colour(hue, sat, bri, predict_colour(hue, sat, bri),
                     quiet ? 0 : $urandom_range(0, MAX_GAP));
      end

      // drop start, wait for the last colours, then allow for stray strobes
      start <= 1'b0;
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_hsv_to_rgb_converter: PASS");
      end else begin
         $display("tb_hsv_to_rgb_converter: FAIL");
      end
      $finish;
   end

   // Result check: rsp_valid lasts exactly one cycle, so sample mid-cycle and
   // compare against the oldest colour owed.
   always @(negedge clock) begin : result_check
      colour_type want;
      if (rsp_valid === 1'b1) begin
         if (pending_colours.size() == 0) begin
            $error("unexpected colour: red %0d green %0d blue %0d rejected %0b",
                   rsp_red, rsp_green, rsp_blue, rsp_input_rejected);
            mismatch_count++;
         end else begin
            want = pending_colours.pop_front();
            if (rsp_red !== want.red) begin
               $error("red: expected %0d, got %0d", want.red, rsp_red);
               mismatch_count++;
            end
            if (rsp_green !== want.green) begin
               $error("green: expected %0d, got %0d", want.green, rsp_green);
               mismatch_count++;
            end
            if (rsp_blue !== want.blue) begin
               $error("blue: expected %0d, got %0d", want.blue, rsp_blue);
               mismatch_count++;
            end
            if (rsp_input_rejected !== want.rejected) begin
               $error("input_rejected: expected %0b, got %0b",
                      want.rejected, rsp_input_rejected);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog: count cycles and end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_hsv_to_rgb_converter: FAIL");
      $finish;
   end

endmodule
